[hw/rtl/mbp_pkg.sv]
// Shared types, codes and helper functions for the MIDI byte parser.
// Used by the parser front, the result queue, the output stage and the top level.
package mbp_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_CHANNEL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_EXTENSION  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSING_DELAY = 2'd2;

   localparam logic [6:0]  RX_CHAN_RESET  = 7'd16;
   localparam logic [6:0]  RX_CHAN_ALL    = 7'h10;
   localparam logic [6:0]  RX_EXT_ANY     = 7'h7F;
   localparam logic [19:0] SENSE_DLY_RESET = 20'd48000;

   // event codes
   localparam logic [3:0] EV_OFF     = 4'd0;
   localparam logic [3:0] EV_ON      = 4'd1;
   localparam logic [3:0] EV_CTRL    = 4'd2;
   localparam logic [3:0] EV_NRPN    = 4'd3;
   localparam logic [3:0] EV_PROG    = 4'd4;
   localparam logic [3:0] EV_PREQ    = 4'd5;
   localparam logic [3:0] EV_CLOCK   = 4'd6;
   localparam logic [3:0] EV_START   = 4'd7;
   localparam logic [3:0] EV_CONT    = 4'd8;
   localparam logic [3:0] EV_STOP    = 4'd9;
   localparam logic [3:0] EV_SENSE   = 4'd10;
   localparam logic [3:0] EV_TIMEOUT = 4'd11;

   // status high nibbles
   localparam logic [3:0] HI_NOTE_OFF = 4'h8;
   localparam logic [3:0] HI_NOTE_ON  = 4'h9;
   localparam logic [3:0] HI_POLY_AT  = 4'hA;
   localparam logic [3:0] HI_CTRL     = 4'hB;
   localparam logic [3:0] HI_PROG     = 4'hC;
   localparam logic [3:0] HI_CHAN_AT  = 4'hD;
   localparam logic [3:0] HI_BEND     = 4'hE;
   localparam logic [3:0] HI_SYSTEM   = 4'hF;

   // system status bytes
   localparam logic [7:0] ST_PREQ  = 8'hF1;
   localparam logic [7:0] ST_EXT   = 8'hF3;
   localparam logic [7:0] ST_EOX   = 8'hF7;
   localparam logic [7:0] ST_CLOCK = 8'hF8;
   localparam logic [7:0] ST_START = 8'hFA;
   localparam logic [7:0] ST_CONT  = 8'hFB;
   localparam logic [7:0] ST_STOP  = 8'hFC;
   localparam logic [7:0] ST_SENSE = 8'hFE;

   // controller numbers
   localparam logic [7:0] CC_DATA_MSB  = 8'd6;
   localparam logic [7:0] CC_DATA_LSB  = 8'd38;
   localparam logic [7:0] CC_NRPN_LSB  = 8'd98;
   localparam logic [7:0] CC_NRPN_MSB  = 8'd99;
   localparam logic [7:0] CC_BEND_MSB  = 8'd128;
   localparam logic [7:0] CC_CHAN_AT   = 8'd129;
   localparam logic [7:0] CC_POLY_AT   = 8'd130;
   localparam logic [7:0] CC_BEND_LSB  = 8'd160;

   // parse phase
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_FIRST  = 2'd1;
   localparam logic [1:0] PH_SECOND = 2'd2;

   typedef struct packed {
      logic [3:0] event_res;
      logic [3:0] chan;
      logic [7:0] number;
      logic [7:0] level;
      logic [7:0] param_lsb;
      logic [7:0] data_low;
   } res_type;

   // all results of one request
   typedef struct packed {
      logic    two;
      res_type first_res;
      res_type second_res;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic res_type mk_res(input logic [3:0] ev, input logic [3:0] ch,
                                      input logic [7:0] num, input logic [7:0] lvl,
                                      input logic [7:0] pl, input logic [7:0] dl);
      res_type r;
      r.event_res = ev;
      r.chan      = ch;
      r.number    = num;
      r.level     = lvl;
      r.param_lsb = pl;
      r.data_low  = dl;
      return r;
   endfunction

   function automatic logic needs_data(input logic [7:0] s);
      return (s[7] && (s[7:4] != HI_SYSTEM)) || (s == ST_PREQ) || (s == ST_EXT);
   endfunction

   function automatic logic is_skip(input logic [7:0] s);
      return (s == 8'hF0) || (s == 8'hF2) || (s == 8'hF4) || (s == 8'hF5) ||
             (s == 8'hF6) || (s == 8'hF9) || (s == 8'hFD) || (s == 8'hFF) ||
             (s == 8'h00);
   endfunction

endpackage

[hw/rtl/midi_byte_parser_nrpn_assembler_top.sv]
// MIDI byte parser with running status, NRPN assembly and active-sensing timer.
// Request channel (req_*): one MIDI byte (req_mode 0) or a tick of elapsed samples
// (req_mode 1) per request. Response channel (rsp_*): zero, one or two events per
// request; rsp_last marks the final event of a request. csr_* writes rx_channel,
// rx_extension and sensing_delay; write them only while the block is idle.
// The first event of an accepted request reaches rsp_valid through the queue write
// and then the output register. The block takes one request per cycle while the
// queue is not full and sends one event per cycle while the receiver is ready; a
// pitchbend request gives two events, sent one at a time through the single output
// register. Requests that give no event push nothing into the queue.
// Reset clears the parse state, sets the registers to their defaults (all channels,
// any extension, 48000 samples) and empties the queue.
// When the receiver stalls, the output register holds its event and the front keeps
// parsing into a QUEUE_DEPTH-entry queue; req_ready drops only when it is full.
// Depends on mbp_pkg, mbp_front, mbp_queue and mbp_back.
module midi_byte_parser_nrpn_assembler_top
   import mbp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [7:0]            req_byte_in,
   input  logic [15:0]           req_sample_count,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_event_res,
   output logic [3:0]            rsp_chan,
   output logic [7:0]            rsp_number,
   output logic [7:0]            rsp_level,
   output logic [7:0]            rsp_param_lsb,
   output logic [7:0]            rsp_data_low,
   output logic                  rsp_last
);

   q_stat_type q_stat;
   logic       q_push;
   bundle_type q_push_data;
   logic       q_pop;
   bundle_type q_pop_data;
   res_type    rsp_res;

   mbp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_byte_in      (req_byte_in),
      .req_sample_count (req_sample_count),
      .q_stat           (q_stat),
      .push             (q_push),
      .push_data        (q_push_data)
   );

   mbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .stat      (q_stat)
   );

   mbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .pop_data  (q_pop_data),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (rsp_res),
      .rsp_last  (rsp_last)
   );

   assign rsp_event_res = rsp_res.event_res;
   assign rsp_chan      = rsp_res.chan;
   assign rsp_number    = rsp_res.number;
   assign rsp_level     = rsp_res.level;
   assign rsp_param_lsb = rsp_res.param_lsb;
   assign rsp_data_low  = rsp_res.data_low;

   // a bundle is never written into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("result bundle pushed into full queue");

   // only pitchbend yields a pair, and both halves are controllers
   a_pair_is_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_event_res == EV_CTRL)
      else $error("non-final event that is not a controller");

   // timeout always stands alone on channel zero
   a_timeout_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_TIMEOUT |-> rsp_last && rsp_chan == 4'd0)
      else $error("malformed timeout event");

   // nothing leaves the block right after reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

[hw/rtl/mbp_front.sv]
// Parser front: configuration registers, running-status parse state, NRPN assembly
// and the active-sensing timer. Pushes at most one bundle per request. Uses mbp_pkg.
module mbp_front
   import mbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [7:0]            req_byte_in,
   input  logic [15:0]           req_sample_count,
   input  q_stat_type            q_stat,
   output logic                  push,
   output bundle_type            push_data
);

   logic [6:0]  rx_chan_ff, rx_chan_in;
   logic [6:0]  rx_ext_ff, rx_ext_in;
   logic [19:0] delay_ff, delay_in;

   logic [7:0]  rs_ff, rs_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  first_ff, first_in;
   logic        excl_ff, excl_in;
   logic [7:0]  ext_ff, ext_in;
   logic [7:0]  nmsb_ff, nmsb_in;
   logic [7:0]  nlsb_ff, nlsb_in;
   logic [7:0]  ndl_ff, ndl_in;
   logic signed [21:0] sense_ff, sense_in;
   logic signed [21:0] sense_diff;

   logic        accept;
   logic [3:0]  ch;
   logic [3:0]  hi;
   logic [7:0]  d;
   logic        pass;
   logic        do_first, do_second;
   logic        ctl_go;
   logic [7:0]  ctl_num, ctl_val;
   logic        produce, two;
   res_type     r0, r1;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign ch        = rs_ff[3:0];
   assign hi        = rs_ff[7:4];
   assign d         = req_byte_in;
   assign sense_diff = sense_ff - $signed({6'b0, req_sample_count});

   assign pass = ((ext_ff == {1'b0, rx_ext_ff}) || (rx_ext_ff == RX_EXT_ANY)) &&
                 ((rx_chan_ff == {3'b0, ch}) || (rx_chan_ff == RX_CHAN_ALL));

   always_comb begin
      rx_chan_in = rx_chan_ff;
      rx_ext_in  = rx_ext_ff;
      delay_in   = delay_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RX_CHANNEL:    rx_chan_in = csr_wdata[6:0];
            CSR_RX_EXTENSION:  rx_ext_in  = csr_wdata[6:0];
            CSR_SENSING_DELAY: delay_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      rs_in     = rs_ff;
      phase_in  = phase_ff;
      first_in  = first_ff;
      excl_in   = excl_ff;
      ext_in    = ext_ff;
      nmsb_in   = nmsb_ff;
      nlsb_in   = nlsb_ff;
      ndl_in    = ndl_ff;
      sense_in  = sense_ff;
      do_first  = 1'b0;
      do_second = 1'b0;
      ctl_go    = 1'b0;
      ctl_num   = '0;
      ctl_val   = '0;
      produce   = 1'b0;
      two       = 1'b0;
      r0        = '0;
      r1        = '0;
      if (accept) begin
         if (req_mode) begin
            if (sense_ff > 22'sd0) begin
               sense_in = sense_diff;
               if (sense_diff < 22'sd0) begin
                  produce = 1'b1;
                  r0 = mk_res(EV_TIMEOUT, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0);
               end
            end
         end else if (excl_ff) begin
            // swallow everything through end of exclusive
            if (d == ST_EOX) excl_in = 1'b0;
         end else if (phase_ff == PH_SECOND) begin
            do_second = 1'b1;
         end else if (phase_ff == PH_FIRST) begin
            do_first = 1'b1;
         end else if (d[7]) begin
            rs_in = d;
            if (needs_data(d)) begin
               phase_in = PH_FIRST;
            end else begin
               case (d)
                  ST_CLOCK: begin
                     produce = 1'b1;
                     r0 = mk_res(EV_CLOCK, d[3:0], 8'd0, 8'd0, 8'd0, 8'd0);
                  end
                  ST_START: begin
                     produce = 1'b1;
                     r0 = mk_res(EV_START, d[3:0], 8'd0, 8'd0, 8'd0, 8'd0);
                  end
                  ST_CONT: begin
                     produce = 1'b1;
                     r0 = mk_res(EV_CONT, d[3:0], 8'd0, 8'd0, 8'd0, 8'd0);
                  end
                  ST_STOP: begin
                     produce = 1'b1;
                     r0 = mk_res(EV_STOP, d[3:0], 8'd0, 8'd0, 8'd0, 8'd0);
                  end
                  ST_SENSE: begin
                     produce = 1'b1;
                     r0 = mk_res(EV_SENSE, d[3:0], 8'd0, 8'd0, 8'd0, 8'd0);
                     sense_in = $signed({2'b0, delay_ff});
                  end
                  ST_EOX: ;
                  default: excl_in = 1'b1;
               endcase
            end
         end else if (needs_data(rs_ff)) begin
            do_first = 1'b1;
         end else if (is_skip(rs_ff)) begin
            excl_in = 1'b1;
         end
         // data under a no-data status falls through and is dropped

         if (do_first) begin
            phase_in = PH_IDLE;
            case (hi)
               HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CTRL, HI_BEND: begin
                  first_in = d;
                  phase_in = PH_SECOND;
               end
               HI_PROG: begin
                  produce = 1'b1;
                  r0 = mk_res(EV_PROG, ch, d, 8'd0, 8'd0, 8'd0);
               end
               HI_CHAN_AT: begin
                  ctl_go  = 1'b1;
                  ctl_num = CC_CHAN_AT;
                  ctl_val = d;
               end
               default: begin
                  if (rs_ff == ST_PREQ) begin
                     produce = 1'b1;
                     r0 = mk_res(EV_PREQ, ch, d, 8'd0, 8'd0, 8'd0);
                  end else if (rs_ff == ST_EXT) begin
                     ext_in = d;
                  end
               end
            endcase
         end

         if (do_second) begin
            phase_in = PH_IDLE;
            case (hi)
               HI_NOTE_OFF: begin
                  produce = 1'b1;
                  r0 = mk_res(EV_OFF, ch, first_ff, 8'd0, 8'd0, 8'd0);
               end
               HI_NOTE_ON: begin
                  produce = 1'b1;
                  if (d != 8'd0) r0 = mk_res(EV_ON, ch, first_ff, d, 8'd0, 8'd0);
                  else r0 = mk_res(EV_OFF, ch, first_ff, 8'd0, 8'd0, 8'd0);
               end
               HI_POLY_AT: begin
                  ctl_go  = 1'b1;
                  ctl_num = CC_POLY_AT;
                  ctl_val = d;
               end
               HI_CTRL: begin
                  ctl_go  = 1'b1;
                  ctl_num = first_ff;
                  ctl_val = d;
               end
               HI_BEND: begin
                  // both halves go out as plain controllers
                  if (pass) begin
                     produce = 1'b1;
                     two     = 1'b1;
                     r0 = mk_res(EV_CTRL, ch, CC_BEND_LSB, first_ff, 8'd0, 8'd0);
                     r1 = mk_res(EV_CTRL, ch, CC_BEND_MSB, d, 8'd0, 8'd0);
                  end
               end
               default: ;
            endcase
         end

         if (ctl_go && pass) begin
            case (ctl_num)
               CC_NRPN_MSB: nmsb_in = ctl_val;
               CC_NRPN_LSB: nlsb_in = ctl_val;
               CC_DATA_LSB: ndl_in  = ctl_val;
               CC_DATA_MSB: begin
                  produce = 1'b1;
                  r0 = mk_res(EV_NRPN, ch, nmsb_ff, ctl_val, nlsb_ff, ndl_ff);
                  ndl_in = 8'd0;
               end
               default: begin
                  produce = 1'b1;
                  r0 = mk_res(EV_CTRL, ch, ctl_num, ctl_val, 8'd0, 8'd0);
               end
            endcase
         end
      end
   end

   assign push                 = accept && produce;
   assign push_data.two        = two;
   assign push_data.first_res  = r0;
   assign push_data.second_res = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_chan_ff <= RX_CHAN_RESET;
         rx_ext_ff  <= RX_EXT_ANY;
         delay_ff   <= SENSE_DLY_RESET;
         rs_ff      <= '0;
         phase_ff   <= PH_IDLE;
         first_ff   <= '0;
         excl_ff    <= 1'b0;
         ext_ff     <= 8'h7F;
         nmsb_ff    <= 8'h7F;
         nlsb_ff    <= 8'h7F;
         ndl_ff     <= '0;
         sense_ff   <= '1;
      end else begin
         rx_chan_ff <= rx_chan_in;
         rx_ext_ff  <= rx_ext_in;
         delay_ff   <= delay_in;
         rs_ff      <= rs_in;
         phase_ff   <= phase_in;
         first_ff   <= first_in;
         excl_ff    <= excl_in;
         ext_ff     <= ext_in;
         nmsb_ff    <= nmsb_in;
         nlsb_ff    <= nlsb_in;
         ndl_ff     <= ndl_in;
         sense_ff   <= sense_in;
      end
   end

endmodule

[hw/rtl/mbp_queue.sv]
// Short FIFO of result bundles between the parser front and the output stage.
// Depends on mbp_pkg for the bundle and status types.
module mbp_queue
   import mbp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   input  logic       pop,
   output bundle_type pop_data,
   output q_stat_type stat
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type     mem_ff [DEPTH];
   logic [IW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/mbp_back.sv]
// Output stage: takes bundles from the queue and sends their results one per
// cycle unless stalled, via a registered response port. Depends on mbp_pkg.
module mbp_back
   import mbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_stat_type q_stat,
   input  bundle_type pop_data,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output res_type    rsp_res,
   output logic       rsp_last
);

   logic    valid_ff, valid_in;
   logic    half_ff, half_in;
   res_type res_ff, res_in;
   logic    last_ff, last_in;
   logic    load;
   logic    sel_last;

   assign load     = !q_stat.empty && (!valid_ff || rsp_ready);
   assign sel_last = half_ff || !pop_data.two;
   // release the bundle once its final result is loaded
   assign pop      = load && sel_last;

   always_comb begin
      valid_in = valid_ff;
      half_in  = half_ff;
      res_in   = res_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = half_ff ? pop_data.second_res : pop_data.first_res;
         last_in  = sel_last;
         half_in  = !sel_last;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;
   assign rsp_last  = last_ff;

endmodule
